### hw/rtl/stc_pkg.sv
// Package for the scalar type converter: type codes, beat structs and
// conversion functions. No dependencies.
`timescale 1ns / 1ps
package stc_pkg;

  localparam logic [2:0] T_BOOL   = 3'd0;
  localparam logic [2:0] T_CHAR   = 3'd1;
  localparam logic [2:0] T_I32    = 3'd2;
  localparam logic [2:0] T_I64    = 3'd3;
  localparam logic [2:0] T_U32    = 3'd4;
  localparam logic [2:0] T_U64    = 3'd5;
  localparam logic [2:0] T_DBL    = 3'd6;
  // unused type code: converts to zero with no flag
  localparam logic [2:0] T_UNUSED = 3'd7;

  // 1.0e-16 as IEEE double bits
  localparam logic [63:0] EPS_BITS = 64'h3C9C_D2B2_97D8_89BC;

  typedef struct packed {
    logic [2:0]  source_type;
    logic [2:0]  target_type;
    logic [63:0] value_bits;
  } stc_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        out_of_range;
  } stc_out_t;

  // Narrow a 64-bit value to the target integer type.
  function automatic logic [63:0] narrow(input logic [63:0] v, input logic [2:0] t);
    logic [63:0] r;
    case (t)
      T_BOOL:  r = {63'd0, |v};
      T_CHAR:  r = {56'd0, v[7:0]};
      T_I32:   r = {{32{v[31]}}, v[31:0]};
      T_U32:   r = {32'd0, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/stc_int2dbl.sv
// Integer sign/magnitude to IEEE double, round to nearest even.
// Depends on stc_pkg.
`timescale 1ns / 1ps
module stc_int2dbl
  import stc_pkg::*;
(
  input  logic        neg,
  input  logic [63:0] mag,
  output logic [63:0] dbl
);
  logic [5:0]  p;
  logic [63:0] norm;
  logic [52:0] mant;
  logic [53:0] mant_rnd;
  logic        lsb, guard, sticky, up;
  logic [10:0] ex;

  // find leading one
  always_comb begin
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) p = 6'(i);
    end
  end

  // normalize so the leading one sits at bit 63
  assign norm   = mag << (6'd63 - p);
  assign mant   = norm[63:11];
  assign lsb    = norm[11];
  assign guard  = norm[10];
  assign sticky = |norm[9:0];
  assign up     = guard && (sticky || lsb);
  assign mant_rnd = {1'b0, mant} + {53'd0, up};

  always_comb begin
    ex = 11'd1023 + {5'd0, p};
    if (mant_rnd[53]) ex = ex + 11'd1;
    if (mag == 64'd0) dbl = 64'd0;
    else dbl = {neg, ex, mant_rnd[53] ? 52'd0 : mant_rnd[51:0]};
  end
endmodule

### hw/rtl/stc_dbl2int.sv
// IEEE double to integer target, truncate toward zero and saturate.
// Depends on stc_pkg.
`timescale 1ns / 1ps
module stc_dbl2int
  import stc_pkg::*;
(
  input  logic [63:0] b,
  input  logic [2:0]  t,
  output logic [63:0] res,
  output logic        flag
);
  logic        neg, big, isnan, sgn;
  logic [10:0] ex;
  logic [51:0] fr;
  logic [10:0] sh;
  logic [63:0] mag, maxp, maxn;
  logic [116:0] wide;

  assign neg = b[63];
  assign ex  = b[62:52];
  assign fr  = b[51:0];
  assign sh  = ex - 11'd1023;
  assign wide = {64'd0, 1'b1, fr} << sh[5:0];

  // magnitude of the truncated value
  always_comb begin
    big = 1'b0;
    isnan = 1'b0;
    mag = 64'd0;
    if (ex == 11'h7FF) begin
      big = 1'b1;
      isnan = fr != 52'd0;
    end else if (ex >= 11'd1023) begin
      if (sh >= 11'd64) big = 1'b1;
      else mag = wide[115:52];
    end
  end

  // saturation limits per target
  always_comb begin
    case (t)
      T_CHAR:  begin sgn = 1'b0; maxp = 64'hFF; end
      T_I32:   begin sgn = 1'b1; maxp = 64'h7FFF_FFFF; end
      T_I64:   begin sgn = 1'b1; maxp = 64'h7FFF_FFFF_FFFF_FFFF; end
      T_U32:   begin sgn = 1'b0; maxp = 64'hFFFF_FFFF; end
      default: begin sgn = 1'b0; maxp = 64'hFFFF_FFFF_FFFF_FFFF; end
    endcase
    maxn = sgn ? maxp + 64'd1 : 64'd0;
  end

  always_comb begin
    flag = 1'b0;
    if (isnan || (!neg && (big || mag > maxp))) begin
      flag = 1'b1;
      res = narrow(maxp, t);
    end else if (neg && (big || mag > maxn)) begin
      flag = 1'b1;
      res = narrow(64'd0 - maxn, t);
    end else begin
      res = narrow(neg ? 64'd0 - mag : mag, t);
    end
  end
endmodule

### hw/rtl/scalar_type_converter.sv
// Top level of the scalar type converter: input register, conversion logic,
// output register. Depends on stc_pkg, stc_int2dbl, stc_dbl2int.
`timescale 1ns / 1ps
//  channel | ports                   | beat
//  in      | in_valid/in_stall/in_data   | stc_in_t
//  out     | out_valid/out_stall/out_data | stc_out_t
// One beat per cycle while out_stall is low; input, then output register.
// Reset (synchronous, rst_n low) clears both valid flags.
// An out stall holds the output register; the input register still takes a
// beat when the output register is free or being drained this cycle.
module scalar_type_converter
  import stc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  stc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output stc_out_t out_data
);
  logic     s1_valid_r, s1_valid_nxt, out_valid_r, out_valid_nxt;
  stc_in_t  s1_r;
  stc_out_t out_r, conv;
  logic     adv_out, adv_in;
  logic [63:0] v, i2d, d2i;
  logic        neg, d2i_flag, isnan;

  assign adv_out  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv_out;
  assign adv_in   = in_valid && !in_stall;

  // extend integer source to 64 bits
  always_comb begin
    case (s1_r.source_type)
      T_BOOL:  v = {63'd0, |s1_r.value_bits};
      T_CHAR:  v = {56'd0, s1_r.value_bits[7:0]};
      T_I32:   v = {{32{s1_r.value_bits[31]}}, s1_r.value_bits[31:0]};
      T_U32:   v = {32'd0, s1_r.value_bits[31:0]};
      default: v = s1_r.value_bits;
    endcase
  end
  assign neg = (s1_r.source_type == T_I32 || s1_r.source_type == T_I64) && v[63];

  stc_int2dbl u_i2d (.neg(neg), .mag(neg ? 64'd0 - v : v), .dbl(i2d));
  stc_dbl2int u_d2i (.b(s1_r.value_bits), .t(s1_r.target_type), .res(d2i),
                     .flag(d2i_flag));

  assign isnan = (s1_r.value_bits[62:52] == 11'h7FF) && (s1_r.value_bits[51:0] != 52'd0);

  // select the conversion
  always_comb begin
    conv = '0;
    if (s1_r.source_type == T_UNUSED || s1_r.target_type == T_UNUSED) begin
      conv = '0;
    end else if (s1_r.source_type == T_DBL) begin
      if (s1_r.target_type == T_DBL) begin
        conv.result_bits = s1_r.value_bits;
      end else if (s1_r.target_type == T_BOOL) begin
        conv.result_bits = {63'd0, !isnan && (s1_r.value_bits[62:0] > EPS_BITS[62:0])};
        conv.out_of_range = isnan;
      end else begin
        conv.result_bits = d2i;
        conv.out_of_range = d2i_flag;
      end
    end else if (s1_r.target_type == T_DBL) begin
      conv.result_bits = i2d;
    end else begin
      conv.result_bits = narrow(v, s1_r.target_type);
    end
  end

  assign s1_valid_nxt  = adv_in ? 1'b1 : (adv_out ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv_out ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);

  // advance the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (adv_in) s1_r <= in_data;
    if (adv_out) out_r <= conv;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  // input is stalled only when stage one is full and the output is blocked
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("spurious input stall");
  // a registered item reaches the output next cycle when not blocked
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_stall |=> out_valid)
    else $error("item lost");
endmodule
